// ----- sv/psrr_pkg.sv -----
// Shared constants, types and codes of the priority round-robin scheduler.
package psrr_pkg;

   localparam int MAX_TASKS = 16;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   localparam int ID_W    = 8;
   localparam int PRI_W   = 4;
   localparam int BURST_W = 16;
   localparam int TQ_W    = 8;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_TASKS);
   localparam logic [TQ_W-1:0]   TQ_RESET  = TQ_W'(10);

   typedef enum logic [0:0] {
      CMD_ADD  = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRI_W-1:0]   pri;
      logic [BURST_W-1:0] rem;
   } entry_type;

endpackage

// ----- sv/psrr_ifs.sv -----
// Handshake channels of the scheduler: request, response and quantum write.
interface psrr_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [psrr_pkg::ID_W-1:0]        task_id;
   logic [psrr_pkg::PRI_W-1:0]       task_priority;
   logic [psrr_pkg::BURST_W-1:0]     burst_length;

   modport source (output valid, command, task_id, task_priority, burst_length,
                   input ready);
   modport sink   (input valid, command, task_id, task_priority, burst_length,
                   output ready);
endinterface

interface psrr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [psrr_pkg::ID_W-1:0]        served_id;
   logic [psrr_pkg::BURST_W-1:0]     slice_length;
   logic                             task_finished;
   logic                             nothing_ready;
   logic                             table_full;

   modport source (output valid, served_id, slice_length, task_finished,
                   nothing_ready, table_full, input ready);
   modport sink   (input valid, served_id, slice_length, task_finished,
                   nothing_ready, table_full, output ready);
endinterface

interface psrr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [psrr_pkg::TQ_W-1:0]        time_quantum;

   modport source (output valid, time_quantum, input ready);
   modport sink   (input valid, time_quantum, output ready);
endinterface

// ----- sv/priority_round_robin_scheduler.sv -----
// Add: accept, then the response state. Step: a scan of every filled slot, a decide state
// and, when the task leaves, a shift from the slot after it to close up the table.
// One item in flight; the next is taken once its response sits in the output register.
// Rate is set by the single read port of the task memory, read by the scan and by the shift.
// Reset (synchronous) clears the table count, round-robin pointer, quantum (to 10) and
// handshakes; task memory contents are not cleared and need no clearing pass.
module priority_round_robin_scheduler (
   input  logic             clock,
   input  logic             reset,
   psrr_req_if.sink         req_if,
   psrr_rsp_if.source       rsp_if,
   psrr_csr_if.sink         csr_if
);

   // task table memory, one registered read port, one write port
   psrr_pkg::entry_type task_mem [psrr_pkg::MAX_TASKS];
   psrr_pkg::entry_type rd_data_ff;
   logic [psrr_pkg::SLOT_W-1:0] mem_raddr;
   logic [psrr_pkg::SLOT_W-1:0] mem_waddr;
   psrr_pkg::entry_type         mem_wdata;
   logic                        mem_we;

   psrr_pkg::state_type state_ff, state_in;
   logic [psrr_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [psrr_pkg::SLOT_W-1:0] last_ff, last_in;
   logic [psrr_pkg::TQ_W-1:0]   tq_ff;
   logic [psrr_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic                        proc_ff, proc_in;
   logic [psrr_pkg::SLOT_W-1:0] pidx_ff, pidx_in;

   // scan trackers
   logic [psrr_pkg::PRI_W-1:0]   top_ff, top_in;
   logic [1:0]                   cnt_ff, cnt_in;
   logic [psrr_pkg::SLOT_W-1:0]  first_slot_ff, first_slot_in;
   logic [psrr_pkg::ID_W-1:0]    first_id_ff, first_id_in;
   logic [psrr_pkg::BURST_W-1:0] first_rem_ff, first_rem_in;
   logic                         aft_ok_ff, aft_ok_in;
   logic [psrr_pkg::SLOT_W-1:0]  aft_slot_ff, aft_slot_in;
   logic [psrr_pkg::ID_W-1:0]    aft_id_ff, aft_id_in;
   logic [psrr_pkg::BURST_W-1:0] aft_rem_ff, aft_rem_in;

   // pending result
   logic [psrr_pkg::ID_W-1:0]    res_id_ff, res_id_in;
   logic [psrr_pkg::BURST_W-1:0] res_slice_ff, res_slice_in;
   logic                         res_fin_ff, res_fin_in;
   logic                         res_none_ff, res_none_in;
   logic                         res_full_ff, res_full_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [psrr_pkg::ID_W-1:0]    rsp_id_ff;
   logic [psrr_pkg::BURST_W-1:0] rsp_slice_ff;
   logic                         rsp_fin_ff, rsp_none_ff, rsp_full_ff;
   logic                         rsp_load;

   logic                         req_fire;
   logic                         issue;
   logic                         lone;
   logic [psrr_pkg::SLOT_W-1:0]  sel_slot;
   logic [psrr_pkg::ID_W-1:0]    sel_id;
   logic [psrr_pkg::BURST_W-1:0] sel_rem;
   logic [psrr_pkg::BURST_W-1:0] quantum;
   logic                         done;
   logic                         new_top;

   assign req_if.ready = (state_ff == psrr_pkg::ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.served_id     = rsp_id_ff;
   assign rsp_if.slice_length  = rsp_slice_ff;
   assign rsp_if.task_finished = rsp_fin_ff;
   assign rsp_if.nothing_ready = rsp_none_ff;
   assign rsp_if.table_full    = rsp_full_ff;

   // selection made after the scan; the cyclic search from last+1 is the first
   // top-priority slot above last, else the first one overall
   assign lone     = (cnt_ff == 2'd1);
   assign sel_slot = (!lone && aft_ok_ff) ? aft_slot_ff : first_slot_ff;
   assign sel_id   = (!lone && aft_ok_ff) ? aft_id_ff   : first_id_ff;
   assign sel_rem  = (!lone && aft_ok_ff) ? aft_rem_ff  : first_rem_ff;
   assign quantum  = {{(psrr_pkg::BURST_W - psrr_pkg::TQ_W){1'b0}},
                      (tq_ff == '0) ? psrr_pkg::TQ_W'(1) : tq_ff};
   assign done     = lone || (sel_rem <= quantum);
   assign issue    = (idx_ff < fill_ff);
   assign new_top  = (pidx_ff == '0) || (rd_data_ff.pri > top_ff);
   assign rsp_load = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      proc_in       = 1'b0;
      pidx_in       = pidx_ff;
      top_in        = top_ff;
      cnt_in        = cnt_ff;
      first_slot_in = first_slot_ff;
      first_id_in   = first_id_ff;
      first_rem_in  = first_rem_ff;
      aft_ok_in     = aft_ok_ff;
      aft_slot_in   = aft_slot_ff;
      aft_id_in     = aft_id_ff;
      aft_rem_in    = aft_rem_ff;
      res_id_in     = res_id_ff;
      res_slice_in  = res_slice_ff;
      res_fin_in    = res_fin_ff;
      res_none_in   = res_none_ff;
      res_full_in   = res_full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      mem_raddr     = idx_ff[psrr_pkg::SLOT_W-1:0];
      mem_waddr     = fill_ff[psrr_pkg::SLOT_W-1:0];
      mem_wdata     = '{id: req_if.task_id, pri: req_if.task_priority,
                        rem: req_if.burst_length};
      mem_we        = 1'b0;

      unique case (state_ff)
         psrr_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_id_in    = '0;
               res_slice_in = '0;
               res_fin_in   = 1'b0;
               res_none_in  = 1'b0;
               res_full_in  = 1'b0;
               state_in     = psrr_pkg::ST_RESP;
               if (req_if.command == psrr_pkg::CMD_ADD) begin
                  if (fill_ff >= psrr_pkg::FULL_CNT) begin
                     res_full_in = 1'b1;
                  end else begin
                     mem_we  = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  res_none_in = 1'b1;
               end else begin
                  idx_in   = '0;
                  state_in = psrr_pkg::ST_SCAN;
               end
            end
         end
         psrr_pkg::ST_SCAN: begin
            if (issue) begin
               proc_in = 1'b1;
               pidx_in = idx_ff[psrr_pkg::SLOT_W-1:0];
               idx_in  = idx_ff + 1'b1;
            end
            if (proc_ff) begin
               if (new_top) begin
                  top_in        = rd_data_ff.pri;
                  cnt_in        = 2'd1;
                  first_slot_in = pidx_ff;
                  first_id_in   = rd_data_ff.id;
                  first_rem_in  = rd_data_ff.rem;
                  aft_ok_in     = (pidx_ff > last_ff);
                  aft_slot_in   = pidx_ff;
                  aft_id_in     = rd_data_ff.id;
                  aft_rem_in    = rd_data_ff.rem;
               end else if (rd_data_ff.pri == top_ff) begin
                  if (cnt_ff != 2'd2) begin
                     cnt_in = cnt_ff + 2'd1;
                  end
                  if (!aft_ok_ff && (pidx_ff > last_ff)) begin
                     aft_ok_in   = 1'b1;
                     aft_slot_in = pidx_ff;
                     aft_id_in   = rd_data_ff.id;
                     aft_rem_in  = rd_data_ff.rem;
                  end
               end
            end
            if (!issue && !proc_ff) begin
               state_in = psrr_pkg::ST_DECIDE;
            end
         end
         psrr_pkg::ST_DECIDE: begin
            res_id_in    = sel_id;
            res_slice_in = done ? sel_rem : quantum;
            res_fin_in   = done;
            if (done) begin
               if (lone || sel_slot == '0) begin
                  last_in = psrr_pkg::LAST_SLOT;
               end else begin
                  last_in = sel_slot - 1'b1;
               end
               idx_in   = psrr_pkg::CNT_W'(sel_slot) + 1'b1;
               state_in = psrr_pkg::ST_SHIFT;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = sel_slot;
               mem_wdata = '{id: sel_id, pri: top_ff, rem: sel_rem - quantum};
               last_in   = sel_slot;
               state_in  = psrr_pkg::ST_RESP;
            end
         end
         psrr_pkg::ST_SHIFT: begin
            // close up the table: entry i+1 moves to slot i
            if (issue) begin
               proc_in = 1'b1;
               pidx_in = idx_ff[psrr_pkg::SLOT_W-1:0];
               idx_in  = idx_ff + 1'b1;
            end
            if (proc_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pidx_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
            if (!issue && !proc_ff) begin
               fill_in  = fill_ff - 1'b1;
               state_in = psrr_pkg::ST_RESP;
            end
         end
         psrr_pkg::ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = psrr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psrr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= task_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psrr_pkg::ST_IDLE;
         fill_ff      <= '0;
         last_ff      <= psrr_pkg::LAST_SLOT;
         tq_ff        <= psrr_pkg::TQ_RESET;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         proc_ff      <= proc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            tq_ff <= csr_if.time_quantum;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pidx_ff       <= pidx_in;
      top_ff        <= top_in;
      cnt_ff        <= cnt_in;
      first_slot_ff <= first_slot_in;
      first_id_ff   <= first_id_in;
      first_rem_ff  <= first_rem_in;
      aft_ok_ff     <= aft_ok_in;
      aft_slot_ff   <= aft_slot_in;
      aft_id_ff     <= aft_id_in;
      aft_rem_ff    <= aft_rem_in;
      res_id_ff     <= res_id_in;
      res_slice_ff  <= res_slice_in;
      res_fin_ff    <= res_fin_in;
      res_none_ff   <= res_none_in;
      res_full_ff   <= res_full_in;
      if (state_ff == psrr_pkg::ST_RESP && rsp_load) begin
         rsp_id_ff    <= res_id_ff;
         rsp_slice_ff <= res_slice_ff;
         rsp_fin_ff   <= res_fin_ff;
         rsp_none_ff  <= res_none_ff;
         rsp_full_ff  <= res_full_ff;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= psrr_pkg::FULL_CNT)
      else $error("task count beyond table size");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.command == psrr_pkg::CMD_ADD && fill_ff < psrr_pkg::FULL_CNT)
      |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("accepted add did not grow the table");

   a_shift_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psrr_pkg::ST_SHIFT && state_in == psrr_pkg::ST_RESP)
      |=> fill_ff == $past(fill_ff) - 1'b1)
      else $error("finished task did not leave the table");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_fin_ff, rsp_none_ff, rsp_full_ff}))
      else $error("conflicting response flags");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psrr_pkg::ST_DECIDE) |-> (cnt_ff != 2'd0 && fill_ff != '0))
      else $error("slice chosen from an empty scan");

endmodule
